// ===== rtl/gap_pkg.sv =====
package gap_pkg;

    // list and page limits
    localparam int MAX_FREE_RECTS = 64;
    localparam int MAX_PAGES      = 256;

    localparam int IDX_W  = $clog2(MAX_FREE_RECTS);
    localparam int CNT_W  = $clog2(MAX_FREE_RECTS + 1);
    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

    // field widths
    localparam int POS_W  = 10;
    localparam int SIZE_W = 11;
    localparam int SEL_W  = 2;

    // apb address map
    localparam int PADDR_W = 3;
    localparam logic REG_PAGE_SIZE = 1'b0;

    // page edges
    localparam logic [SIZE_W-1:0] EDGE_256  = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] EDGE_512  = SIZE_W'(512);
    localparam logic [SIZE_W-1:0] EDGE_1024 = SIZE_W'(1024);

    typedef enum logic [1:0] {
        ST_PLACED     = 2'd0,
        ST_TOO_LARGE  = 2'd1,
        ST_DROPPED    = 2'd2,
        ST_PAGE_LIMIT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_MISS,
        S_PUSH_R,
        S_PUSH_B,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]  left;
        logic [POS_W-1:0]  top;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } rect_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } rd_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        rect_t            data;
    } wr_req_t;

    // edge of a newly opened page, selector three acts as two
    function automatic logic [SIZE_W-1:0] page_edge(input logic [SEL_W-1:0] sel);
        logic [SIZE_W-1:0] e;
        case (sel)
            2'd0:    e = EDGE_256;
            2'd1:    e = EDGE_512;
            default: e = EDGE_1024;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/gap_if.sv =====
interface gap_in_if;
    logic                       valid;
    logic                       ready;
    logic [gap_pkg::SIZE_W-1:0] glyph_width;
    logic [gap_pkg::SIZE_W-1:0] glyph_height;

    modport source (output valid, output glyph_width, output glyph_height, input ready);
    modport sink   (input valid, input glyph_width, input glyph_height, output ready);
endinterface

interface gap_out_if;
    logic                      valid;
    logic                      ready;
    logic [7:0]                page_index;
    logic [gap_pkg::POS_W-1:0] pos_x;
    logic [gap_pkg::POS_W-1:0] pos_y;
    logic                      opened_page;
    logic [1:0]                status;

    modport source (output valid, output page_index, output pos_x, output pos_y,
                    output opened_page, output status, input ready);
    modport sink   (input valid, input page_index, input pos_x, input pos_y,
                    input opened_page, input status, output ready);
endinterface

// ===== rtl/glyph_atlas_rect_packer.sv =====
// Guillotine first-fit glyph packer. An item carries a glyph size; the block
// scans the open page's ordered free-rectangle list held in a single-port-read
// RAM, one entry a cycle, takes the first entry that fits, closes the gap by
// moving each later entry down one slot (one read and one write a cycle), then
// appends the right and bottom remnants. A glyph that is too large skips the
// scan and goes straight to its result; an item whose scan misses opens a new
// page instead, unless the page limit is reached. A result that still waits in
// the output register holds the engine back before it loads the next one. A
// new item is taken while the previous result still waits in the output
// register. page_size_select (APB offset 0) sets the edge of pages opened
// afterwards.
module glyph_atlas_rect_packer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gap_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    gap_in_if.sink                      glyph_in,
    gap_out_if.source                   place_out
);

    gap_pkg::state_t state_reg, state_next;

    logic [gap_pkg::SEL_W-1:0]  cfg_sel_reg;
    logic [gap_pkg::CNT_W-1:0]  count_reg, count_next;
    logic [gap_pkg::PAGE_W-1:0] page_reg, page_next;
    logic                       page_open_reg, page_open_next;
    logic                       out_valid_reg, out_valid_next;

    logic [gap_pkg::SIZE_W-1:0] w_reg, w_next, h_reg, h_next;
    logic [gap_pkg::SIZE_W-1:0] edge_reg, edge_next;
    logic [gap_pkg::SIZE_W-1:0] rw_reg, rw_next, rh_reg, rh_next;
    logic [gap_pkg::POS_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [gap_pkg::IDX_W-1:0]  ptr_reg, ptr_next;
    gap_pkg::status_t           status_reg, status_next;
    logic                       opened_reg, opened_next;

    logic [7:0]                 out_page_reg, out_page_next;
    logic [gap_pkg::POS_W-1:0]  out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic                       out_opened_reg, out_opened_next;
    logic [1:0]                 out_status_reg, out_status_next;

    gap_pkg::rd_req_t rd_req;
    gap_pkg::wr_req_t wr_req;
    gap_pkg::rect_t   rdata;

    logic                       in_acc, too_large, fit, load_out, page_limit;
    logic [gap_pkg::SIZE_W-1:0] in_edge, rem_w, rem_h;
    logic [gap_pkg::CNT_W-1:0]  ptr_ext, ptr_inc, cnt_dec;
    logic [gap_pkg::SIZE_W-1:0] x_plus_w, y_plus_h;
    logic [gap_pkg::PAGE_W:0]   page_inc;
    logic                       list_room;

    // apb register
    assign pready = 1'b1;
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == gap_pkg::REG_PAGE_SIZE)
        begin
            prdata = {{(32 - gap_pkg::SEL_W){1'b0}}, cfg_sel_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_sel_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == gap_pkg::REG_PAGE_SIZE)
        begin
            cfg_sel_reg <= pwdata[gap_pkg::SEL_W-1:0];
        end
    end

    // free-list memory
    gap_rect_ram u_ram (
        .clk   (clk),
        .rd    (rd_req),
        .wr    (wr_req),
        .rdata (rdata)
    );

    // shared decode
    assign glyph_in.ready = (state_reg == gap_pkg::S_IDLE);
    assign in_acc    = glyph_in.valid && glyph_in.ready;
    assign in_edge   = gap_pkg::page_edge(cfg_sel_reg);
    assign too_large = (glyph_in.glyph_width == '0) || (glyph_in.glyph_height == '0) ||
                       (glyph_in.glyph_width > in_edge) || (glyph_in.glyph_height > in_edge);
    assign fit       = (rdata.width >= w_reg) && (rdata.height >= h_reg);
    assign ptr_ext   = {{(gap_pkg::CNT_W - gap_pkg::IDX_W){1'b0}}, ptr_reg};
    assign ptr_inc   = ptr_ext + gap_pkg::CNT_W'(1);
    assign cnt_dec   = count_reg - gap_pkg::CNT_W'(1);
    assign page_inc  = {1'b0, page_reg} + (gap_pkg::PAGE_W + 1)'(1);
    assign page_limit = page_open_reg && (page_inc >= (gap_pkg::PAGE_W + 1)'(gap_pkg::MAX_PAGES));
    assign rem_w     = rw_reg - w_reg;
    assign rem_h     = rh_reg - h_reg;
    assign x_plus_w  = {1'b0, x_reg} + w_reg;
    assign y_plus_h  = {1'b0, y_reg} + h_reg;
    assign list_room = count_reg < gap_pkg::CNT_W'(gap_pkg::MAX_FREE_RECTS);
    assign load_out  = (state_reg == gap_pkg::S_DONE) && (!out_valid_reg || place_out.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gap_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (too_large)
                        state_next = gap_pkg::S_DONE;
                    else if (page_open_reg && count_reg != '0)
                        state_next = gap_pkg::S_SCAN;
                    else
                        state_next = gap_pkg::S_MISS;
                end
            end
            gap_pkg::S_SCAN:
            begin
                if (fit)
                    state_next = (ptr_ext < cnt_dec) ? gap_pkg::S_SHIFT : gap_pkg::S_PUSH_R;
                else if (ptr_inc >= count_reg)
                    state_next = gap_pkg::S_MISS;
            end
            gap_pkg::S_SHIFT:
            begin
                if (ptr_ext >= count_reg)
                    state_next = gap_pkg::S_PUSH_R;
            end
            gap_pkg::S_MISS:
            begin
                state_next = page_limit ? gap_pkg::S_DONE : gap_pkg::S_PUSH_R;
            end
            gap_pkg::S_PUSH_R: state_next = gap_pkg::S_PUSH_B;
            gap_pkg::S_PUSH_B: state_next = gap_pkg::S_DONE;
            gap_pkg::S_DONE:
            begin
                if (load_out)
                    state_next = gap_pkg::S_IDLE;
            end
            default: state_next = gap_pkg::S_IDLE;
        endcase
    end

    // datapath and memory strobes
    always_comb
    begin
        count_next      = count_reg;
        page_next       = page_reg;
        page_open_next  = page_open_reg;
        w_next          = w_reg;
        h_next          = h_reg;
        edge_next       = edge_reg;
        rw_next         = rw_reg;
        rh_next         = rh_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        ptr_next        = ptr_reg;
        status_next     = status_reg;
        opened_next     = opened_reg;
        out_page_next   = out_page_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_opened_next = out_opened_reg;
        out_status_next = out_status_reg;
        rd_req          = '0;
        wr_req          = '0;

        case (state_reg)
            gap_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    w_next      = glyph_in.glyph_width;
                    h_next      = glyph_in.glyph_height;
                    edge_next   = in_edge;
                    x_next      = '0;
                    y_next      = '0;
                    opened_next = 1'b0;
                    ptr_next    = '0;
                    status_next = too_large ? gap_pkg::ST_TOO_LARGE : gap_pkg::ST_PLACED;
                    if (!too_large && page_open_reg && count_reg != '0)
                    begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = '0;
                    end
                end
            end
            gap_pkg::S_SCAN:
            begin
                // rdata holds entry ptr_reg
                if (fit)
                begin
                    x_next     = rdata.left;
                    y_next     = rdata.top;
                    rw_next    = rdata.width;
                    rh_next    = rdata.height;
                    count_next = cnt_dec;
                    if (ptr_ext < cnt_dec)
                    begin
                        rd_req.en   = 1'b1;
                        rd_req.addr = ptr_inc[gap_pkg::IDX_W-1:0];
                        ptr_next    = ptr_inc[gap_pkg::IDX_W-1:0];
                    end
                end
                else if (ptr_inc < count_reg)
                begin
                    rd_req.en   = 1'b1;
                    rd_req.addr = ptr_inc[gap_pkg::IDX_W-1:0];
                    ptr_next    = ptr_inc[gap_pkg::IDX_W-1:0];
                end
            end
            gap_pkg::S_SHIFT:
            begin
                // move entry ptr_reg down one slot
                wr_req.en   = 1'b1;
                wr_req.addr = ptr_reg - gap_pkg::IDX_W'(1);
                wr_req.data = rdata;
                if (ptr_ext < count_reg)
                begin
                    rd_req.en   = 1'b1;
                    rd_req.addr = ptr_inc[gap_pkg::IDX_W-1:0];
                    ptr_next    = ptr_inc[gap_pkg::IDX_W-1:0];
                end
            end
            gap_pkg::S_MISS:
            begin
                if (page_limit)
                begin
                    status_next = gap_pkg::ST_PAGE_LIMIT;
                end
                else
                begin
                    if (page_open_reg)
                        page_next = page_inc[gap_pkg::PAGE_W-1:0];
                    page_open_next = 1'b1;
                    opened_next    = 1'b1;
                    count_next     = '0;
                    x_next         = '0;
                    y_next         = '0;
                    rw_next        = edge_reg;
                    rh_next        = edge_reg;
                end
            end
            gap_pkg::S_PUSH_R:
            begin
                // right remnant
                if (rem_w != '0)
                begin
                    if (list_room)
                    begin
                        wr_req.en          = 1'b1;
                        wr_req.addr        = count_reg[gap_pkg::IDX_W-1:0];
                        wr_req.data.left   = x_plus_w[gap_pkg::POS_W-1:0];
                        wr_req.data.top    = y_reg;
                        wr_req.data.width  = rem_w;
                        wr_req.data.height = h_reg;
                        count_next         = count_reg + gap_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        status_next = gap_pkg::ST_DROPPED;
                    end
                end
            end
            gap_pkg::S_PUSH_B:
            begin
                // bottom remnant
                if (rem_h != '0)
                begin
                    if (list_room)
                    begin
                        wr_req.en          = 1'b1;
                        wr_req.addr        = count_reg[gap_pkg::IDX_W-1:0];
                        wr_req.data.left   = x_reg;
                        wr_req.data.top    = y_plus_h[gap_pkg::POS_W-1:0];
                        wr_req.data.width  = w_reg;
                        wr_req.data.height = rem_h;
                        count_next         = count_reg + gap_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        status_next = gap_pkg::ST_DROPPED;
                    end
                end
            end
            gap_pkg::S_DONE:
            begin
                if (load_out)
                begin
                    out_page_next   = 8'(page_reg);
                    out_x_next      = x_reg;
                    out_y_next      = y_reg;
                    out_opened_next = opened_reg;
                    out_status_next = status_reg;
                end
            end
            default: ;
        endcase
    end

    // output valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && place_out.ready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gap_pkg::S_IDLE;
            count_reg     <= '0;
            page_reg      <= '0;
            page_open_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            page_reg      <= page_next;
            page_open_reg <= page_open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        w_reg          <= w_next;
        h_reg          <= h_next;
        edge_reg       <= edge_next;
        rw_reg         <= rw_next;
        rh_reg         <= rh_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        ptr_reg        <= ptr_next;
        status_reg     <= status_next;
        opened_reg     <= opened_next;
        out_page_reg   <= out_page_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_opened_reg <= out_opened_next;
        out_status_reg <= out_status_next;
    end

    assign place_out.valid       = out_valid_reg;
    assign place_out.page_index  = out_page_reg;
    assign place_out.pos_x       = out_x_reg;
    assign place_out.pos_y       = out_y_reg;
    assign place_out.opened_page = out_opened_reg;
    assign place_out.status      = out_status_reg;

endmodule

// ===== rtl/gap_rect_ram.sv =====
module gap_rect_ram (
    input  logic             clk,
    input  gap_pkg::rd_req_t rd,
    input  gap_pkg::wr_req_t wr,
    output gap_pkg::rect_t   rdata
);

    gap_pkg::rect_t mem [gap_pkg::MAX_FREE_RECTS];

    // one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rdata <= mem[rd.addr];
        end
    end

endmodule

// ===== rtl/gap_checker.sv =====
module gap_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [7:0]                page_index,
    input logic [gap_pkg::POS_W-1:0] pos_x,
    input logic [gap_pkg::POS_W-1:0] pos_y,
    input logic                      opened_page,
    input logic [1:0]                status
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(page_index) && $stable(pos_x)
                                    && $stable(pos_y) && $stable(status))
        else $error("stalled result changed");

    // one item at a time in the engine
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item taken while engine busy");

    // rejected items carry no position and open no page
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == gap_pkg::ST_TOO_LARGE || status == gap_pkg::ST_PAGE_LIMIT)
        |-> !opened_page && pos_x == '0 && pos_y == '0)
        else $error("rejected item with position");

    // a fresh page places at its origin
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && opened_page |-> pos_x == '0 && pos_y == '0)
        else $error("new page not placed at origin");

endmodule

bind glyph_atlas_rect_packer gap_checker u_gap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (glyph_in.valid),
    .in_ready    (glyph_in.ready),
    .out_valid   (place_out.valid),
    .out_ready   (place_out.ready),
    .page_index  (place_out.page_index),
    .pos_x       (place_out.pos_x),
    .pos_y       (place_out.pos_y),
    .opened_page (place_out.opened_page),
    .status      (place_out.status)
);
